@@ rtl/core/nsf_pkg.sv @@
// Package for the NMEA sentence framer: character codes, sentence kind codes,
// the tag table and the result beat type. Depends on nothing.
`default_nettype none

package nsf_pkg;

    localparam int MAX_LEN_DEFAULT = 128;
    localparam int BYTE_W          = 8;
    localparam int KIND_W          = 3;
    localparam int LEN_W           = 7;
    localparam int TAG_COUNT       = 5;

    localparam logic [BYTE_W-1:0] CHAR_START   = 8'h24;  // '$'
    localparam logic [BYTE_W-1:0] CHAR_STAR    = 8'h2A;  // '*'
    localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'h0A;  // line feed
    localparam logic [BYTE_W-1:0] CHAR_COMMA   = 8'h2C;  // ','
    localparam logic [BYTE_W-1:0] CHAR_NUL     = 8'h00;

    localparam logic [KIND_W-1:0] KIND_UNKNOWN = 3'd0;
    localparam logic [KIND_W-1:0] KIND_GGA     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_RMC     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_GST     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_GSV     = 3'd4;
    localparam logic [KIND_W-1:0] KIND_GSA     = 3'd5;

    // Three tag letters, oldest first, in reporting priority order.
    localparam logic [3*BYTE_W-1:0] TAG_TEXT [TAG_COUNT] = '{
        24'h474741,  // GGA
        24'h524D43,  // RMC
        24'h475354,  // GST
        24'h475356,  // GSV
        24'h475341   // GSA
    };

    localparam logic [KIND_W-1:0] TAG_KIND [TAG_COUNT] = '{
        KIND_GGA, KIND_RMC, KIND_GST, KIND_GSV, KIND_GSA
    };

    typedef struct packed {
        logic              checksum_ok;
        logic [KIND_W-1:0] sentence_kind;
        logic [LEN_W-1:0]  sentence_length;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/core/nsf_byte_if.sv @@
// Channel that carries one received byte per beat.
// Depends on nsf_pkg for the byte width.
`default_nettype none

interface nsf_byte_if;
    logic                       valid;
    logic                       ready;
    logic [nsf_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

@@ rtl/core/nsf_result_if.sv @@
// Channel that carries one sentence summary per beat.
// Depends on nsf_pkg for the field widths.
`default_nettype none

interface nsf_result_if;
    logic                       valid;
    logic                       ready;
    logic                       checksum_ok;
    logic [nsf_pkg::KIND_W-1:0] sentence_kind;
    logic [nsf_pkg::LEN_W-1:0]  sentence_length;

    modport source (output valid, output checksum_ok, output sentence_kind,
                    output sentence_length, input ready);
    modport sink   (input valid, input checksum_ok, input sentence_kind,
                    input sentence_length, output ready);
endinterface

`default_nettype wire

@@ rtl/core/nsf_tracker.sv @@
// Per-sentence state: length count, running XOR, checksum digit parser and
// tag window. Produces one summary on the closing line feed. Uses nsf_pkg.
`default_nettype none

module nsf_tracker #(
    parameter int MAX_LEN = nsf_pkg::MAX_LEN_DEFAULT
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       accept,
    input  wire logic [nsf_pkg::BYTE_W-1:0] rx_byte,
    output logic                            result_valid,
    output nsf_pkg::result_t                result
);

    localparam int CNT_W = $clog2(MAX_LEN);
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_LEN - 1);

    typedef enum logic [1:0] {
        PH_BEFORE_STAR,
        PH_HIGH_DIGIT,
        PH_LOW_DIGIT,
        PH_DONE
    } phase_t;

    // Returns {bad, value}; bad is set for anything that is not a hex digit.
    function automatic logic [4:0] hex_decode(input logic [nsf_pkg::BYTE_W-1:0] c);
        logic [4:0] r;
        begin
            if (c >= 8'h30 && c <= 8'h39)
                r = {1'b0, 4'(c - 8'h30)};
            else if (c >= 8'h41 && c <= 8'h46)
                r = {1'b0, 4'(c - 8'h37)};
            else if (c >= 8'h61 && c <= 8'h66)
                r = {1'b0, 4'(c - 8'h57)};
            else
                r = 5'b1_0000;
            return r;
        end
    endfunction

    logic                          in_sentence_reg, in_sentence_next;
    logic [CNT_W-1:0]              byte_count_reg, byte_count_next;
    logic [nsf_pkg::BYTE_W-1:0]    running_xor_reg, running_xor_next;
    phase_t                        phase_reg, phase_next;
    logic [nsf_pkg::BYTE_W-1:0]    received_sum_reg, received_sum_next;
    logic                          digits_ok_reg, digits_ok_next;
    logic                          string_ended_reg, string_ended_next;
    logic [3*nsf_pkg::BYTE_W-1:0]  window_reg, window_next;
    logic [nsf_pkg::TAG_COUNT-1:0] tag_found_reg, tag_found_next;

    logic [4:0]                    digit;
    logic [nsf_pkg::KIND_W-1:0]    kind;

    // Checksum verdict from the values as they stand after this byte.
    logic                          ok_now;
    logic                          ph_done_after;
    logic                          dig_ok_after;
    logic [nsf_pkg::BYTE_W-1:0]    xor_after;
    logic [nsf_pkg::BYTE_W-1:0]    sum_after;

    always_comb
    begin
        in_sentence_next  = in_sentence_reg;
        byte_count_next   = byte_count_reg;
        running_xor_next  = running_xor_reg;
        phase_next        = phase_reg;
        received_sum_next = received_sum_reg;
        digits_ok_next    = digits_ok_reg;
        string_ended_next = string_ended_reg;
        window_next       = window_reg;
        tag_found_next    = tag_found_reg;
        result_valid      = 1'b0;
        digit             = hex_decode(rx_byte);
        kind              = nsf_pkg::KIND_UNKNOWN;

        if (accept) begin
            if (rx_byte == nsf_pkg::CHAR_START) begin
                // A start mark restarts from scratch, even mid sentence.
                in_sentence_next  = 1'b1;
                byte_count_next   = CNT_W'(1);
                running_xor_next  = '0;
                phase_next        = PH_BEFORE_STAR;
                received_sum_next = '0;
                digits_ok_next    = 1'b1;
                string_ended_next = 1'b0;
                window_next       = {16'h0000, nsf_pkg::CHAR_START};
                tag_found_next    = '0;
            end else if (in_sentence_reg) begin
                byte_count_next = byte_count_reg + CNT_W'(1);

                if (!string_ended_reg) begin
                    if (rx_byte == nsf_pkg::CHAR_NUL) begin
                        string_ended_next = 1'b1;
                        if (phase_reg == PH_HIGH_DIGIT || phase_reg == PH_LOW_DIGIT)
                            digits_ok_next = 1'b0;
                    end else begin
                        case (phase_reg)
                            PH_BEFORE_STAR:
                            begin
                                if (rx_byte == nsf_pkg::CHAR_STAR)
                                    phase_next = PH_HIGH_DIGIT;
                                else
                                    running_xor_next = running_xor_reg ^ rx_byte;
                            end
                            PH_HIGH_DIGIT, PH_LOW_DIGIT:
                            begin
                                if (digit[4])
                                    digits_ok_next = 1'b0;
                                else
                                    received_sum_next = {received_sum_reg[3:0], digit[3:0]};
                                phase_next = (phase_reg == PH_HIGH_DIGIT) ? PH_LOW_DIGIT
                                                                          : PH_DONE;
                            end
                            default:
                            begin
                                phase_next = phase_reg;
                            end
                        endcase

                        if (rx_byte == nsf_pkg::CHAR_COMMA) begin
                            for (int t = 0; t < nsf_pkg::TAG_COUNT; t++) begin
                                if (window_reg == nsf_pkg::TAG_TEXT[t])
                                    tag_found_next[t] = 1'b1;
                            end
                        end
                        window_next = {window_reg[2*nsf_pkg::BYTE_W-1:0], rx_byte};
                    end
                end

                // First tag in priority order wins.
                for (int t = nsf_pkg::TAG_COUNT - 1; t >= 0; t--) begin
                    if (tag_found_next[t])
                        kind = nsf_pkg::TAG_KIND[t];
                end

                if (byte_count_reg >= CNT_LIMIT || rx_byte == nsf_pkg::CHAR_NEWLINE) begin
                    result_valid      = (byte_count_reg < CNT_LIMIT);
                    in_sentence_next  = 1'b0;
                    byte_count_next   = '0;
                    running_xor_next  = '0;
                    phase_next        = PH_BEFORE_STAR;
                    received_sum_next = '0;
                    digits_ok_next    = 1'b1;
                    string_ended_next = 1'b0;
                    window_next       = '0;
                    tag_found_next    = '0;
                end
            end
        end
    end

    always_comb
    begin
        result.sentence_kind   = kind;
        result.sentence_length = nsf_pkg::LEN_W'(byte_count_reg + CNT_W'(1));
        result.checksum_ok     = ok_now;
    end

    always_comb
    begin
        ph_done_after = 1'b0;
        dig_ok_after  = digits_ok_reg;
        xor_after     = running_xor_reg;
        sum_after     = received_sum_reg;
        if (string_ended_reg) begin
            ph_done_after = (phase_reg == PH_DONE);
        end else begin
            case (phase_reg)
                PH_BEFORE_STAR:
                begin
                    // The line feed does not join the XOR; no star was seen.
                    ph_done_after = 1'b0;
                end
                PH_HIGH_DIGIT:
                begin
                    ph_done_after = 1'b0;
                end
                PH_LOW_DIGIT:
                begin
                    // A line feed is never a hex digit.
                    ph_done_after = 1'b1;
                    dig_ok_after  = 1'b0;
                end
                default:
                begin
                    ph_done_after = 1'b1;
                end
            endcase
        end
        ok_now = ph_done_after && dig_ok_after && (xor_after == sum_after);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_sentence_reg  <= 1'b0;
            byte_count_reg   <= '0;
            running_xor_reg  <= '0;
            phase_reg        <= PH_BEFORE_STAR;
            received_sum_reg <= '0;
            digits_ok_reg    <= 1'b1;
            string_ended_reg <= 1'b0;
            window_reg       <= '0;
            tag_found_reg    <= '0;
        end else begin
            in_sentence_reg  <= in_sentence_next;
            byte_count_reg   <= byte_count_next;
            running_xor_reg  <= running_xor_next;
            phase_reg        <= phase_next;
            received_sum_reg <= received_sum_next;
            digits_ok_reg    <= digits_ok_next;
            string_ended_reg <= string_ended_next;
            window_reg       <= window_next;
            tag_found_reg    <= tag_found_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/nsf_out_buf.sv @@
// Two-entry output stage: a result register plus a skid register, so the
// input side waits only while both hold a result. Uses nsf_pkg.
`default_nettype none

module nsf_out_buf (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire nsf_pkg::result_t  push_data,
    output logic                   space,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output nsf_pkg::result_t       out_data
);

    logic             main_valid_reg;
    logic             skid_valid_reg;
    nsf_pkg::result_t main_reg;
    nsf_pkg::result_t skid_reg;
    logic             pop;

    assign pop       = main_valid_reg && out_ready;
    assign space     = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop)
                skid_valid_reg <= 1'b0;
        end else if (push && main_valid_reg && !pop) begin
            skid_valid_reg <= 1'b1;
        end else if (push) begin
            main_valid_reg <= 1'b1;
        end else if (pop) begin
            main_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg) begin
            if (pop)
                main_reg <= skid_reg;
        end else if (push && main_valid_reg && !pop) begin
            skid_reg <= push_data;
        end else if (push) begin
            main_reg <= push_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/nmea_sentence_framer.sv @@
// Top level of the NMEA 0183 sentence framer.
// Depends on nsf_pkg, nsf_byte_if, nsf_result_if, nsf_tracker and nsf_out_buf.
`default_nettype none

// The framer takes one received character per beat on rx and returns one
// summary beat on sentence for every sentence that closes with a line feed.
// A '$' always opens a new sentence, discarding any sentence in progress;
// characters outside a sentence are dropped silently. The summary reports
// whether the two hex digits after the first '*' (either case) equal the XOR
// of every character strictly between '$' and that '*', which of the tags
// GGA, RMC, GST, GSV or GSA (in that priority) was seen followed by a comma,
// and the sentence length including '$' and the line feed, modulo 128. A zero
// character ends the visible text: later characters still count toward the
// length but no longer feed the checksum or the tag search. A sentence that
// would grow past MAX_LEN - 1 characters is abandoned without a summary.
// Every character is handled in the cycle it is accepted, so rx takes one
// beat per clock. The summary sits in a result register backed by a skid
// register; rx.ready drops only when both hold a summary that sentence.ready
// has not yet taken, so the input stalls only under sustained back-pressure.
// Summaries are registered, into the skid register if the result one is full.

module nmea_sentence_framer #(
    parameter int MAX_LEN = nsf_pkg::MAX_LEN_DEFAULT
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    nsf_byte_if.sink        rx,
    nsf_result_if.source    sentence
);

    logic             accept;
    logic             space;
    logic             result_valid;
    nsf_pkg::result_t result;
    nsf_pkg::result_t out_data;

    // A beat is taken whenever the skid register is free.
    assign rx.ready = space;
    assign accept   = rx.valid && space;

    // All per-sentence bookkeeping happens here in the accepting cycle.
    nsf_tracker #(
        .MAX_LEN (MAX_LEN)
    ) u_tracker (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .rx_byte      (rx.rx_byte),
        .result_valid (result_valid),
        .result       (result)
    );

    // Result and skid registers that decouple the consumer.
    nsf_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (result_valid),
        .push_data (result),
        .space     (space),
        .out_valid (sentence.valid),
        .out_ready (sentence.ready),
        .out_data  (out_data)
    );

    assign sentence.checksum_ok     = out_data.checksum_ok;
    assign sentence.sentence_kind   = out_data.sentence_kind;
    assign sentence.sentence_length = out_data.sentence_length;

endmodule

`default_nettype wire
